### hw/rtl/rotated_sorted_search_dup_macros.svh
// ----------------------------------------------------------------------------
// rotated_sorted_search_dup_macros.svh
// Assertion helpers shared by the search block.
// ----------------------------------------------------------------------------
`ifndef ROTATED_SORTED_SEARCH_DUP_MACROS_SVH
`define ROTATED_SORTED_SEARCH_DUP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define RSSD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset
`define RSSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hw/rtl/rssd_pkg.sv
// ----------------------------------------------------------------------------
// rssd_pkg
// Shared constants, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rssd_pkg;

    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PTR_W  = CNT_W + 1;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LOW,
        S_RD_MID,
        S_RD_HIGH,
        S_EVAL,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        SEL_LOW,
        SEL_MID,
        SEL_HIGH
    } rd_sel_t;

    typedef struct packed {
        logic    ready;
        rd_sel_t rd_sel;
        logic    cap_vl;
        logic    cap_vm;
        logic    eval;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic hit;
        logic more;
        logic out_free;
    } stat_t;

endpackage

### hw/rtl/rotated_sorted_search_dup.sv
// ----------------------------------------------------------------------------
// rotated_sorted_search_dup
// Membership search in a rotated ascending array that may hold duplicates.
// ----------------------------------------------------------------------------
// Usage:
//   Stream one array element per transaction on the s_ channel; tdata carries
//   the element (low word) and the key (high word); tlast marks the final
//   element, whose key is searched for. Non-final elements are taken at one
//   per cycle. Up to 1024 elements are kept; later ones are discarded and
//   reported through the dropped flag.
//   After the final element the block searches the store and s_tready stays
//   low. Each search step reads low, mid and high through the single read
//   port of the element store, then evaluates them. Steps run from about
//   log2(N) for distinct values up to N/2 when duplicates force the ends to
//   shrink by one. A step that finds the key, or leaves the range empty,
//   ends the search and the result goes to the m_ channel.
//   The result sits in an output register; the block waits there only if an
//   earlier result has not yet been taken, then returns to loading.
//   Reset (aresetn low, synchronous) empties the store and clears any pending
//   result; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "rotated_sorted_search_dup_macros.svh"

module rotated_sorted_search_dup (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] element, [63:32] key
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] found, [1] dropped, [7:2] zero
);
    import rssd_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  found;
    logic  dropped;

    rssd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    rssd_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_valid    (s_tvalid),
        .in_element  (s_tdata[31:0]),
        .in_key      (s_tdata[63:32]),
        .in_last     (s_tlast),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_found   (found),
        .out_dropped (dropped)
    );

    assign s_tready = cmd.ready;
    assign m_tdata  = {6'b0, dropped, found};

    // A final element starts the search and blocks further input
    `RSSD_ASSERT_NEXT(a_search_blocks_input, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready)
    // A new result only comes out of the search, never while loading
    `RSSD_ASSERT_SAME(a_result_after_search, aclk, aresetn, $rose(m_tvalid), !$past(s_tready))
    // Input is never taken in the cycle a result is loaded
    `RSSD_ASSERT_SAME(a_no_accept_on_finish, aclk, aresetn, cmd.finish, !s_tready)

endmodule

### hw/rtl/rssd_ctrl.sv
// ----------------------------------------------------------------------------
// rssd_ctrl
// Sequencer: load phase, three-read/evaluate search loop, result hand-off.
// ----------------------------------------------------------------------------
module rssd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  rssd_pkg::stat_t stat,
    output rssd_pkg::cmd_t  cmd
);
    import rssd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (stat.in_valid && stat.in_last) begin
                    state_next = S_RD_LOW;
                end
            end
            S_RD_LOW:  state_next = S_RD_MID;
            S_RD_MID:  state_next = S_RD_HIGH;
            S_RD_HIGH: state_next = S_EVAL;
            S_EVAL: begin
                if (stat.hit || !stat.more) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_RD_LOW;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        cmd        = '0;
        cmd.rd_sel = SEL_LOW;
        case (state_reg)
            S_IDLE:    cmd.ready = 1'b1;
            S_RD_LOW:  cmd.rd_sel = SEL_LOW;
            S_RD_MID: begin
                cmd.rd_sel = SEL_MID;
                cmd.cap_vl = 1'b1;
            end
            S_RD_HIGH: begin
                cmd.rd_sel = SEL_HIGH;
                cmd.cap_vm = 1'b1;
            end
            S_EVAL:    cmd.eval = 1'b1;
            S_DONE:    cmd.finish = stat.out_free;
            default:   cmd.ready = 1'b0;
        endcase
    end

endmodule

### hw/rtl/rssd_dpath.sv
// ----------------------------------------------------------------------------
// rssd_dpath
// Element store, search pointers, compare logic and result register.
// ----------------------------------------------------------------------------
module rssd_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rssd_pkg::cmd_t              cmd,
    output rssd_pkg::stat_t             stat,
    input  logic                        in_valid,
    input  logic signed [rssd_pkg::DATA_W-1:0] in_element,
    input  logic signed [rssd_pkg::DATA_W-1:0] in_key,
    input  logic                        in_last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_found,
    output logic                        out_dropped
);
    import rssd_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] vl_reg;
    logic signed [DATA_W-1:0] vm_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic        [CNT_W-1:0]  count_reg;
    logic                     overflow_reg;
    logic signed [PTR_W-1:0]  low_reg;
    logic signed [PTR_W-1:0]  high_reg;
    logic                     out_valid_reg;
    logic                     out_found_reg;
    logic                     out_dropped_reg;

    logic                     accept;
    logic                     full;
    logic        [PTR_W:0]    ptr_sum;
    logic signed [PTR_W-1:0]  mid;
    logic        [PTR_W-1:0]  rd_ptr;
    logic        [IDX_W-1:0]  raddr;
    logic signed [DATA_W-1:0] vh;
    logic signed [PTR_W-1:0]  low_next;
    logic signed [PTR_W-1:0]  high_next;
    logic                     hit;

    assign accept = cmd.ready && in_valid;
    assign full   = (count_reg == CNT_W'(DEPTH));

    // Midpoint; both pointers are non-negative inside the loop
    assign ptr_sum = {low_reg[PTR_W-1], low_reg} + {high_reg[PTR_W-1], high_reg};
    assign mid     = ptr_sum[PTR_W:1];

    // Read address select
    always_comb begin
        case (cmd.rd_sel)
            SEL_LOW:  rd_ptr = low_reg;
            SEL_MID:  rd_ptr = mid;
            SEL_HIGH: rd_ptr = high_reg;
            default:  rd_ptr = low_reg;
        endcase
    end
    assign raddr = rd_ptr[IDX_W-1:0];

    // Store: append on accept unless full, registered read
    always_ff @(posedge aclk) begin
        if (accept && !full) begin
            mem[count_reg[IDX_W-1:0]] <= in_element;
        end
        rdata_reg <= mem[raddr];
    end

    // Evaluate one search step; high value arrives straight from the read port
    assign vh  = rdata_reg;
    assign hit = (vm_reg == key_reg);

    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        if (vl_reg == vm_reg && vm_reg == vh) begin
            low_next  = low_reg + PTR_W'(1);
            high_next = high_reg - PTR_W'(1);
        end else if (vl_reg <= vm_reg) begin
            if (vl_reg <= key_reg && key_reg <= vm_reg) begin
                high_next = mid - PTR_W'(1);
            end else begin
                low_next = mid + PTR_W'(1);
            end
        end else begin
            if (vm_reg <= key_reg && key_reg <= vh) begin
                low_next = mid + PTR_W'(1);
            end else begin
                high_next = mid - PTR_W'(1);
            end
        end
    end

    // Capture low/mid values, set up and advance the pointers
    always_ff @(posedge aclk) begin
        if (cmd.cap_vl) begin
            vl_reg <= rdata_reg;
        end
        if (cmd.cap_vm) begin
            vm_reg <= rdata_reg;
        end
        if (accept && in_last) begin
            low_reg  <= '0;
            high_reg <= full ? PTR_W'(DEPTH - 1) : PTR_W'(count_reg);
            key_reg  <= in_key;
        end else if (cmd.eval) begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    // Fill count and overflow flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else if (cmd.finish) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else if (accept) begin
            if (full) begin
                overflow_reg <= 1'b1;
            end else begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // Result register; hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result fields only when the result register is loaded
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_found_reg   <= hit;
            out_dropped_reg <= overflow_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_found   = out_found_reg;
    assign out_dropped = out_dropped_reg;

    // Status to the controller
    always_comb begin
        stat          = '0;
        stat.in_valid = in_valid;
        stat.in_last  = in_last;
        stat.hit      = hit;
        stat.more     = (low_next <= high_next);
        stat.out_free = !out_valid_reg || out_ready;
    end

endmodule

### dv/rotated_sorted_search_dup_tb.sv
// ----------------------------------------------------------------------------
// rotated_sorted_search_dup_tb
// Self-checking bench for the rotated-array search block. Streams arrays of
// signed elements, with the key on the tlast transaction. An in-bench copy of
// the store and of the duplicate-tolerant binary search predicts found and
// dropped for every array. Each m_ transaction is compared in order against
// that prediction.
// ----------------------------------------------------------------------------
module rotated_sorted_search_dup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = rssd_pkg::DEPTH;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 650;
    localparam int MAX_REPORTS = 10;
    localparam int INT_MIN = 32'sh8000_0000;
    localparam int INT_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic found;
        logic dropped;
    } search_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // [31:0] element, [63:32] key
    logic        s_tlast  = 1'b0; // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [0] found, [1] dropped, [7:2] zero

    // Predictor state: a shadow of the element store
    int             element_mem [STORE_DEPTH];
    int             element_cnt   = 0;
    bit             overflow_flag = 1'b0;
    search_result_t expected_results[$];

    bit idle_on     = 1'b1;
    int items_sent  = 0;
    int error_cnt   = 0;
    int cycle_cnt   = 0;

    rotated_sorted_search_dup dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Binary search that shrinks both ends when low, mid and high are equal
    function automatic bit key_in_store(int key);
        int lo, hi, mid, vl, vm, vh;
        lo = 0;
        hi = element_cnt - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            vl  = element_mem[lo];
            vm  = element_mem[mid];
            vh  = element_mem[hi];
            if (vm == key) return 1'b1;
            if (vl == vm && vm == vh) begin
                lo++;
                hi--;
            end else if (vl <= vm) begin
                if (vl <= key && key <= vm) hi = mid - 1;
                else lo = mid + 1;
            end else begin
                if (vm <= key && key <= vh) lo = mid + 1;
                else hi = mid - 1;
            end
        end
        return 1'b0;
    endfunction

    // Update the shadow store for one accepted transaction
    function automatic void record_element(int elem, int key, bit last);
        search_result_t res;
        if (element_cnt < STORE_DEPTH) begin
            element_mem[element_cnt] = elem;
            element_cnt++;
        end else begin
            overflow_flag = 1'b1;
        end
        if (last) begin
            res.found   = key_in_store(key);
            res.dropped = overflow_flag;
            expected_results = {expected_results, res};
            element_cnt   = 0;
            overflow_flag = 1'b0;
        end
    endfunction

    // Compare one result transaction with the oldest prediction
    function automatic void check_result(logic [7:0] beat);
        search_result_t want;
        if (expected_results.size() == 0) begin
            error_cnt++;
            if (error_cnt <= MAX_REPORTS)
                $display("unexpected result: found=%b dropped=%b", beat[0], beat[1]);
            return;
        end
        want = expected_results.pop_front();
        if (beat[0] !== want.found || beat[1] !== want.dropped || beat[7:2] !== 6'd0) begin
            error_cnt++;
            if (error_cnt <= MAX_REPORTS)
                $display("mismatch: expected found=%b dropped=%b, got tdata=%b",
                         want.found, want.dropped, beat);
        end
    endfunction

    // Drive m_tready with random stalls and check every result transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !idle_on || ($urandom_range(99) >= 6);
            if (m_tvalid && m_tready) check_result(m_tdata);
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("rotated_sorted_search_dup_tb: errors");
            $finish;
        end
    end

    // Send one element; hold valid until the transaction is taken
    task automatic send_item(int elem, int key, bit last);
        while (idle_on && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {key, elem};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        record_element(elem, key, last);
        items_sent++;
    endtask

    // Send a whole array; the key rides on the final element, noise elsewhere
    task automatic send_array(int vals[$], int key);
        foreach (vals[i]) begin
            if (i == vals.size() - 1) send_item(vals[i], key, 1'b1);
            else send_item(vals[i], int'($urandom), 1'b0);
        end
    endtask

    // Stop sending and wait until every pending result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Build a rotated ascending array (or plain noise) and a key for it
    task automatic build_array(int n, bit rotated, output int vals[$], output int key);
        int raw[$];
        int base, rot;
        bit narrow;
        narrow = $urandom_range(1);
        base   = $urandom;
        vals   = {};
        for (int i = 0; i < n; i++)
            raw = {raw, (narrow ? base + int'($urandom_range(7)) : int'($urandom))};
        if (rotated) begin
            raw.sort();
            rot = $urandom_range(n - 1);
            for (int i = 0; i < n; i++) vals = {vals, raw[(i + rot) % n]};
        end else begin
            vals = raw;
        end
        case ($urandom_range(3))
            0, 1: key = vals[$urandom_range(n - 1)];
            2:    key = vals[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
            default: key = $urandom;
        endcase
    endtask

    // Corner arrays: single element, integer extremes, duplicates, rotated
    task automatic test_directed();
        int vals[$];
        vals = '{5};
        send_array(vals, 5);
        vals = '{INT_MIN};
        send_array(vals, INT_MAX);
        vals = '{INT_MAX, INT_MIN};
        send_array(vals, INT_MIN);
        vals = '{2, 5, 6, 0, 0, 1, 2};
        send_array(vals, 0);
        vals = '{1, 0, 1, 1, 1};
        send_array(vals, 0);
        vals = '{4, 4, 4, 4};
        send_array(vals, 3);
        vals = '{3, 1, 2};
        send_array(vals, 1);
    endtask

    // Fill the store exactly with equal values and miss: longest search
    task automatic test_full_store();
        int vals[$];
        int v;
        v = $urandom;
        for (int i = 0; i < STORE_DEPTH; i++) vals = {vals, v};
        send_array(vals, v + 1);
    endtask

    // Overrun the store; key taken from the dropped tail or the kept part
    task automatic test_overflow();
        int vals[$];
        int key;
        build_array(STORE_DEPTH + 3, 1'b1, vals, key);
        send_array(vals, vals[STORE_DEPTH + 1]);
        build_array(STORE_DEPTH + 1, 1'b1, vals, key);
        send_array(vals, key);
    endtask

    // Mostly rotated arrays with random content, some unsorted noise
    task automatic test_random();
        int vals[$];
        int key, n, start;
        bit drained;
        start   = items_sent;
        drained = 1'b0;
        while (items_sent - start < RANDOM_ITEMS) begin
            idle_on = !(items_sent - start >= 150 && items_sent - start < 300);
            if (!drained && items_sent - start >= 350) begin
                drain_results();
                drained = 1'b1;
            end
            n = ($urandom_range(99) < 5) ? $urandom_range(25, 200) : $urandom_range(1, 24);
            build_array(n, $urandom_range(99) >= 15, vals, key);
            send_array(vals, key);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        // Hold reset low at the start, then release it
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_store();
        test_overflow();
        test_random();

        // Let the last search finish, then watch for stray results
        drain_results();
        repeat (100) @(posedge aclk);
        if (error_cnt == 0) begin
            $display("rotated_sorted_search_dup_tb: clean");
        end else begin
            $display("rotated_sorted_search_dup_tb: errors");
        end
        $finish;
    end

endmodule
